// ===== rtl/plwg_pkg.sv =====
package plwg_pkg;

  localparam int LEVEL_WIDTH      = 16;
  localparam int TIME_WIDTH       = 16;
  localparam int SINE_TABLE_DEPTH = 256;

  // phase is Q0.16, one extra bit holds the value one
  localparam int PHASE_FRAC  = 16;
  localparam int PHASE_W     = PHASE_FRAC + 1;
  localparam int IDX_W       = $clog2(SINE_TABLE_DEPTH);
  localparam int CNT_W       = $clog2(PHASE_FRAC);
  localparam int STEP_W      = LEVEL_WIDTH + 1;
  localparam int PROD_W      = STEP_W + PHASE_W + 1;
  localparam int ROM_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = (LEVEL_WIDTH > TIME_WIDTH) ? LEVEL_WIDTH : TIME_WIDTH;
  localparam int WAVE_W      = 3;

  localparam logic [IDX_W-1:0] COS_OFFSET = IDX_W'(SINE_TABLE_DEPTH / 4);

  localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd4;

  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_COSINE   = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_SAWTOOTH = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd4;

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] TS_C1   = 64'd1686629713;
  localparam logic [63:0] TS_C3   = 64'd693598669;
  localparam logic [63:0] TS_C5   = 64'd85569306;
  localparam logic [63:0] TS_C7   = 64'd5026995;
  localparam logic [63:0] TS_C9   = 64'd172272;

  typedef struct packed {
    logic load;
    logic div_step;
    logic fact;
    logic mul;
    logic finish;
  } plwg_cmd_t;

  typedef struct packed {
    logic enabled;
    logic div_last;
  } plwg_status_t;

  // (sin(2*pi*i/D)+1)/2 in Q0.16, evaluated at elaboration
  function automatic logic [ROM_W-1:0] sine_entry(input int unsigned i);
    logic [63:0] q4;
    logic [63:0] quad;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] e;
    q4   = 64'(i) * 64'd4;
    quad = q4 / SINE_TABLE_DEPTH;
    u    = ((q4 % SINE_TABLE_DEPTH) << 30) / SINE_TABLE_DEPTH;
    if (quad[0]) u = Q30_ONE - u;
    u2 = (u * u) >> 30;
    r  = TS_C9;
    r  = TS_C7 - ((r * u2) >> 30);
    r  = TS_C5 - ((r * u2) >> 30);
    r  = TS_C3 - ((r * u2) >> 30);
    r  = TS_C1 - ((r * u2) >> 30);
    s  = (r * u) >> 30;
    if (s > Q30_ONE) s = Q30_ONE;
    if (quad >= 64'd2) e = (Q30_ONE - s + 64'd16384) >> 15;
    else e = (Q30_ONE + s + 64'd16384) >> 15;
    if (e > 64'd65535) e = 64'd65535;
    return e[ROM_W-1:0];
  endfunction

endpackage

// ===== rtl/plwg_datapath.sv =====
module plwg_datapath
  import plwg_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  plwg_cmd_t                     cmd,
  output plwg_status_t                  status,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic [TIME_WIDTH-1:0]         tick_delta,
  output logic signed [LEVEL_WIDTH-1:0] level,
  output logic                          descending
);

  logic signed [LEVEL_WIDTH-1:0] start_level;
  logic signed [LEVEL_WIDTH-1:0] end_level;
  logic [TIME_WIDTH-1:0]         period_ticks;
  logic [WAVE_W-1:0]             waveform;
  logic                          cycling_enabled;

  logic [TIME_WIDTH-1:0]         elapsed_time;
  logic                          falling_phase;
  logic signed [LEVEL_WIDTH-1:0] current_level;

  logic [TIME_WIDTH-1:0]         t_cur;
  logic                          dir;
  logic                          at_end;
  logic [TIME_WIDTH-1:0]         rem;
  logic [PHASE_FRAC-1:0]         quo;
  logic [CNT_W-1:0]              cnt;
  logic [PHASE_W-1:0]            factor;
  logic signed [PROD_W-1:0]      prod;

  logic [ROM_W-1:0]              sine_rom [SINE_TABLE_DEPTH];

  logic [TIME_WIDTH-1:0]         period_eff;
  logic [TIME_WIDTH:0]           t_sum;
  logic                          t_over;
  logic [TIME_WIDTH:0]           rem2;
  logic                          rem_ge;
  logic [PHASE_W-1:0]            phase;
  logic [IDX_W-1:0]              rom_idx;
  logic signed [STEP_W-1:0]      step;
  logic signed [PROD_W-1:0]      rounded;
  logic signed [PROD_W-1:0]      level_wide;
  logic signed [LEVEL_WIDTH-1:0] level_next;

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g);
  end

  assign period_eff = (period_ticks == '0) ? TIME_WIDTH'(1) : period_ticks;
  assign t_sum      = {1'b0, elapsed_time} + {1'b0, tick_delta};
  assign t_over     = (t_sum >= {1'b0, period_eff});
  assign rem2       = {rem, 1'b0};
  assign rem_ge     = (rem2 >= {1'b0, period_eff});
  assign phase      = at_end ? {1'b1, {PHASE_FRAC{1'b0}}} : {1'b0, quo};
  assign rom_idx    = phase[PHASE_FRAC-IDX_W +: IDX_W]
                      + ((waveform == WAVE_COSINE) ? COS_OFFSET : '0);
  assign step       = STEP_W'(end_level) - STEP_W'(start_level);
  assign rounded    = (prod + PROD_W'(32768)) >>> PHASE_FRAC;

  always_comb begin
    level_wide = PROD_W'(current_level);
    unique case (waveform)
      WAVE_TRIANGLE: begin
        if (dir) level_wide = PROD_W'(end_level) - rounded;
        else level_wide = PROD_W'(start_level) + rounded;
      end
      WAVE_SINE, WAVE_COSINE, WAVE_SAWTOOTH: begin
        level_wide = PROD_W'(start_level) + rounded;
      end
      WAVE_SQUARE: begin
        level_wide = dir ? PROD_W'(end_level) : PROD_W'(start_level);
      end
      default: level_wide = PROD_W'(current_level);
    endcase
    level_next = level_wide[LEVEL_WIDTH-1:0];
  end

  assign status.enabled  = cycling_enabled;
  assign status.div_last = (cnt == CNT_W'(PHASE_FRAC - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      start_level     <= '0;
      end_level       <= '0;
      period_ticks    <= TIME_WIDTH'(1);
      waveform        <= WAVE_TRIANGLE;
      cycling_enabled <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_LEVEL: start_level     <= cfg_data[LEVEL_WIDTH-1:0];
        REG_END_LEVEL:   end_level       <= cfg_data[LEVEL_WIDTH-1:0];
        REG_PERIOD:      period_ticks    <= cfg_data[TIME_WIDTH-1:0];
        REG_WAVEFORM:    waveform        <= cfg_data[WAVE_W-1:0];
        REG_ENABLE:      cycling_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_time  <= '0;
      falling_phase <= 1'b0;
      current_level <= '0;
    end else if (cmd.finish && cycling_enabled) begin
      current_level <= level_next;
      if (at_end) begin
        elapsed_time  <= '0;
        falling_phase <= ~falling_phase;
      end else begin
        elapsed_time <= t_cur;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_cur  <= t_over ? period_eff : t_sum[TIME_WIDTH-1:0];
      rem    <= t_over ? period_eff : t_sum[TIME_WIDTH-1:0];
      at_end <= t_over;
      dir    <= falling_phase;
      quo    <= '0;
      cnt    <= '0;
    end
    if (cmd.div_step) begin
      quo <= {quo[PHASE_FRAC-2:0], rem_ge};
      rem <= rem_ge ? TIME_WIDTH'(rem2 - {1'b0, period_eff}) : rem2[TIME_WIDTH-1:0];
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.fact) begin
      if (waveform == WAVE_SINE || waveform == WAVE_COSINE) begin
        factor <= {1'b0, sine_rom[rom_idx]};
      end else begin
        factor <= phase;
      end
    end
    if (cmd.mul) begin
      prod <= PROD_W'(step) * PROD_W'(signed'({1'b0, factor}));
    end
    if (cmd.finish) begin
      level      <= cycling_enabled ? level_next : current_level;
      descending <= dir;
    end
  end

endmodule

// ===== rtl/plwg_ctrl.sv =====
module plwg_ctrl
  import plwg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  plwg_status_t status,
  output plwg_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_FACT = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_take;
  logic   slot_free;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          cmd.load   = 1'b1;
          state_next = status.enabled ? S_DIV : S_FIN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_FACT;
      end
      S_FACT: begin
        cmd.fact   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // wait for the output register to free up
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished transaction not presented");

  a_fin_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && out_valid && out_stall |=> (state == S_FIN))
    else $error("result overwritten while output stalled");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_take |=> in_stall)
    else $error("second transaction taken while busy");

  a_no_finish_early: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(out_valid && out_stall))
    else $error("finish while output slot full");

endmodule

// ===== rtl/periodic_level_waveform_generator.sv =====
// an input transaction is taken in idle; with cycling enabled it runs the bit-serial phase
// divider, the factor step and the multiply, then the finish step registers the result
// (with cycling disabled it goes straight to finish); no new transaction is taken before finish
// an output stall holds the result and stops the next transaction at its last step
// rst (synchronous): levels 0, period 1, triangle, disabled, time and direction cleared
module periodic_level_waveform_generator
  import plwg_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [TIME_WIDTH-1:0]         tick_delta,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [LEVEL_WIDTH-1:0] level,
  output logic                          descending
);

  plwg_cmd_t    cmd;
  plwg_status_t status;

  plwg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  plwg_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tick_delta (tick_delta),
    .level      (level),
    .descending (descending)
  );

endmodule

// ===== tb/lfo_level_checker.sv =====
module lfo_level_checker
  import plwg_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [TIME_WIDTH-1:0]         tick_delta,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [LEVEL_WIDTH-1:0] level,
  input  logic                          descending,
  output int                            mismatches,
  output int                            pending,
  output int                            ticks_seen,
  output int                            results_seen,
  output int                            turns,
  output int                            held_ticks
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [LEVEL_WIDTH-1:0] level;
    logic                          descending;
  } lfo_sample_t;

  logic [15:0] half_sine_q16 [SINE_TABLE_DEPTH];

  // register copies
  logic signed [LEVEL_WIDTH-1:0] start_cfg;
  logic signed [LEVEL_WIDTH-1:0] end_cfg;
  logic [TIME_WIDTH-1:0]         period_cfg;
  logic [WAVE_W-1:0]             shape_cfg;
  logic                          cycling_on;

  // running state
  logic [TIME_WIDTH-1:0]         elapsed;
  logic                          falling;
  logic signed [LEVEL_WIDTH-1:0] level_now;

  lfo_sample_t expected_samples [$];

  // (sin + 1) / 2 in Q0.16 from a Q30 Taylor series on the folded quarter wave
  function automatic logic [15:0] half_sine_entry(input int unsigned i);
    logic [63:0] quarter;
    logic [63:0] frac;
    logic [63:0] frac_sq;
    logic [63:0] poly;
    logic [63:0] s;
    logic [63:0] e;
    quarter = (64'(i) * 64'd4) / SINE_TABLE_DEPTH;
    frac    = (((64'(i) * 64'd4) % SINE_TABLE_DEPTH) << 30) / SINE_TABLE_DEPTH;
    if (quarter[0]) frac = Q30_ONE - frac;
    frac_sq = (frac * frac) >> 30;
    poly = TS_C9;
    poly = TS_C7 - ((poly * frac_sq) >> 30);
    poly = TS_C5 - ((poly * frac_sq) >> 30);
    poly = TS_C3 - ((poly * frac_sq) >> 30);
    poly = TS_C1 - ((poly * frac_sq) >> 30);
    s = (poly * frac) >> 30;
    if (s > Q30_ONE) s = Q30_ONE;
    if (quarter >= 64'd2) e = (Q30_ONE - s + 64'd16384) >> 15;
    else e = (Q30_ONE + s + 64'd16384) >> 15;
    if (e > 64'd65535) e = 64'd65535;
    return e[15:0];
  endfunction

  // floor((p + 1/2 lsb) / 2^16)
  function automatic longint scale_q16(input longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic lfo_sample_t next_level(input logic [TIME_WIDTH-1:0] delta);
    lfo_sample_t r;
    longint unsigned per;
    longint unsigned t;
    longint unsigned ph;
    longint unsigned idx;
    longint step;
    r.descending = falling;
    if (cycling_on) begin
      per = (period_cfg == '0) ? 64'd1 : 64'(period_cfg);
      t = 64'(elapsed) + 64'(delta);
      if (t >= per) t = per;
      ph = (t << 16) / per;
      step = longint'(end_cfg) - longint'(start_cfg);
      case (shape_cfg)
        WAVE_TRIANGLE: begin
          if (falling)
            level_now = LEVEL_WIDTH'(end_cfg - scale_q16(step * longint'(ph)));
          else
            level_now = LEVEL_WIDTH'(start_cfg + scale_q16(step * longint'(ph)));
        end
        WAVE_SINE, WAVE_COSINE: begin
          idx = (ph * SINE_TABLE_DEPTH) >> 16;
          if (shape_cfg == WAVE_COSINE) idx = idx + SINE_TABLE_DEPTH / 4;
          idx = idx % SINE_TABLE_DEPTH;
          level_now = LEVEL_WIDTH'(start_cfg
                                   + scale_q16(step * longint'(half_sine_q16[idx])));
        end
        WAVE_SAWTOOTH:
          level_now = LEVEL_WIDTH'(start_cfg + scale_q16(step * longint'(ph)));
        WAVE_SQUARE: level_now = falling ? end_cfg : start_cfg;
        default: ; // spare codes hold the level
      endcase
      if (t == per) begin
        t = 0;
        falling = ~falling;
        turns++;
      end
      elapsed = t[TIME_WIDTH-1:0];
    end else begin
      held_ticks++;
    end
    r.level = level_now;
    return r;
  endfunction

  initial begin
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) half_sine_q16[i] = half_sine_entry(i);
    mismatches   = 0;
    pending      = 0;
    ticks_seen   = 0;
    results_seen = 0;
    turns        = 0;
    held_ticks   = 0;
  end

  always @(posedge clk) begin
    lfo_sample_t want;
    if (rst) begin
      start_cfg  = '0;
      end_cfg    = '0;
      period_cfg = TIME_WIDTH'(1);
      shape_cfg  = WAVE_TRIANGLE;
      cycling_on = 1'b0;
      elapsed    = '0;
      falling    = 1'b0;
      level_now  = '0;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_LEVEL: start_cfg = cfg_data[LEVEL_WIDTH-1:0];
          REG_END_LEVEL:   end_cfg = cfg_data[LEVEL_WIDTH-1:0];
          REG_PERIOD:      period_cfg = cfg_data[TIME_WIDTH-1:0];
          REG_WAVEFORM:    shape_cfg = cfg_data[WAVE_W-1:0];
          REG_ENABLE:      cycling_on = cfg_data[0];
          default: ;
        endcase
      end
      // compare before queuing so a stray result cannot match a new tick
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: level %0d descending %0b with no tick outstanding",
                     $realtime, level, descending);
        end else begin
          want = expected_samples.pop_front();
          if (level !== want.level || descending !== want.descending) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d: level exp %0d got %0d, descending exp %0b got %0b",
                       $realtime, results_seen, want.level, level, want.descending,
                       descending);
          end
        end
      end
      if (in_valid && !in_stall) begin
        ticks_seen++;
        expected_samples.push_back(next_level(tick_delta));
      end
    end
    pending = expected_samples.size();
  end

endmodule

// ===== tb/periodic_level_waveform_generator_tb.sv =====
module periodic_level_waveform_generator_tb;
  import plwg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 30;
  localparam int TICKS_PER_MODE = 290;

  localparam logic signed [LEVEL_WIDTH-1:0] LEVEL_MIN = {1'b1, {(LEVEL_WIDTH-1){1'b0}}};
  localparam logic signed [LEVEL_WIDTH-1:0] LEVEL_MAX = ~LEVEL_MIN;
  localparam logic [TIME_WIDTH-1:0]         PERIOD_MAX = '1;
  localparam logic [WAVE_W-1:0]             WAVE_UNUSED = WAVE_SQUARE + 3'd1;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [TIME_WIDTH-1:0]         tick_delta;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [LEVEL_WIDTH-1:0] level;
  logic                          descending;

  int mismatches;
  int pending;
  int ticks_seen;
  int results_seen;
  int turns;
  int held_ticks;

  int in_idle_pct;
  int out_idle_pct;
  int hold_requests;
  int settings_used;
  int quiet_cycles;

  periodic_level_waveform_generator u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .tick_delta (tick_delta),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .level      (level),
    .descending (descending)
  );

  lfo_level_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .tick_delta   (tick_delta),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level        (level),
    .descending   (descending),
    .mismatches   (mismatches),
    .pending      (pending),
    .ticks_seen   (ticks_seen),
    .results_seen (results_seen),
    .turns        (turns),
    .held_ticks   (held_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stall, or a long hold-off when one is requested
  initial begin
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left   = 0;
    out_stall   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // leaves cfg_we high; the caller drops it after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_lfo(input logic signed [LEVEL_WIDTH-1:0] lo,
                         input logic signed [LEVEL_WIDTH-1:0] hi,
                         input logic [TIME_WIDTH-1:0] per,
                         input logic [WAVE_W-1:0] shape,
                         input logic on);
    write_reg(REG_START_LEVEL, CFG_DATA_W'(lo));
    write_reg(REG_END_LEVEL, CFG_DATA_W'(hi));
    write_reg(REG_PERIOD, CFG_DATA_W'(per));
    write_reg(REG_WAVEFORM, CFG_DATA_W'(shape));
    write_reg(REG_ENABLE, CFG_DATA_W'(on));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_tick(input logic [TIME_WIDTH-1:0] delta);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    tick_delta <= delta;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering ticks until every result is back and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [LEVEL_WIDTH-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return LEVEL_MIN;
      1: return LEVEL_MAX;
      2: return '0;
      default: return LEVEL_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [TIME_WIDTH-1:0] pick_period();
    case ($urandom_range(0, 5))
      0: return TIME_WIDTH'($urandom_range(0, 8));
      1: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return TIME_WIDTH'(1);
          default: return PERIOD_MAX;
        endcase
      end
      2, 3: return TIME_WIDTH'($urandom_range(9, 500));
      4: return TIME_WIDTH'($urandom_range(501, 65535));
      default: return TIME_WIDTH'($urandom);
    endcase
  endfunction

  // mostly small steps so the shape is walked through, with jumps and exact wraps
  function automatic logic [TIME_WIDTH-1:0] pick_delta(input logic [TIME_WIDTH-1:0] per);
    int unsigned p;
    p = (per == '0) ? 1 : per;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return TIME_WIDTH'($urandom);
      2: return TIME_WIDTH'(p - $urandom_range(0, 1));
      default: return TIME_WIDTH'($urandom_range(0, p / 8 + 1));
    endcase
  endfunction

  task automatic run_setting(input int n_ticks, input logic with_hold);
    logic [TIME_WIDTH-1:0] per;
    logic [WAVE_W-1:0]     shape;
    per = pick_period();
    if ($urandom_range(0, 9) == 0) shape = WAVE_W'($urandom_range(5, 7));
    else shape = WAVE_W'($urandom_range(0, 4));
    set_lfo(pick_level(), pick_level(), per, shape, $urandom_range(0, 99) < 85);
    if (with_hold) hold_requests++;
    repeat (n_ticks) send_tick(pick_delta(per));
    settle();
  endtask

  initial begin
    int sent;
    int n;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    tick_delta    = '0;
    in_idle_pct   = 0;
    out_idle_pct  = 0;
    hold_requests = 0;
    settings_used = 0;
    quiet_cycles  = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset state: cycling off, level held at zero
    send_tick('0);
    send_tick('1);
    settle();
    set_lfo(LEVEL_MIN, LEVEL_MAX, PERIOD_MAX, WAVE_TRIANGLE, 1'b1);
    send_tick('0);
    send_tick(16'd32768);
    send_tick('1);
    send_tick('1);
    settle();
    set_lfo(LEVEL_MAX, LEVEL_MIN, 16'd4, WAVE_SINE, 1'b1);
    repeat (4) send_tick(16'd1);
    send_tick(16'd3);
    settle();
    set_lfo(LEVEL_MIN, LEVEL_MAX, 16'd4, WAVE_COSINE, 1'b1);
    send_tick(16'd1);
    send_tick(16'd2);
    send_tick('1);
    settle();
    // zero period counts as one
    set_lfo(LEVEL_MAX, LEVEL_MIN, '0, WAVE_SAWTOOTH, 1'b1);
    send_tick('0);
    send_tick(16'd1);
    settle();
    set_lfo(LEVEL_WIDTH'(-100), LEVEL_WIDTH'(100), 16'd3, WAVE_SQUARE, 1'b1);
    send_tick(16'd3);
    send_tick(16'd3);
    settle();
    // spare shape code: level frozen, time and direction still move
    set_lfo(LEVEL_WIDTH'(-5000), LEVEL_WIDTH'(5000), 16'd10, WAVE_TRIANGLE, 1'b1);
    send_tick(16'd4);
    settle();
    write_reg(REG_WAVEFORM, CFG_DATA_W'(WAVE_UNUSED));
    cfg_we <= 1'b0;
    send_tick(16'd6);
    send_tick(16'd6);
    settle();
    // period cut below the time already run
    set_lfo(LEVEL_WIDTH'(-1000), LEVEL_WIDTH'(1000), 16'd1000, WAVE_TRIANGLE, 1'b1);
    send_tick(16'd900);
    settle();
    write_reg(REG_PERIOD, CFG_DATA_W'(100));
    cfg_we <= 1'b0;
    send_tick('0);
    settle();
    write_reg(REG_ENABLE, '0);
    cfg_we <= 1'b0;
    send_tick(16'd500);
    settle();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin in_idle_pct = 34; out_idle_pct = 77; end
        1: begin in_idle_pct = 77; out_idle_pct = 34; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      sent = 0;
      while (sent < TICKS_PER_MODE) begin
        n = $urandom_range(15, 50);
        run_setting(n, sent == 0 && mode != 1);
        sent += n;
      end
    end

    $display("covered %0d ticks and %0d results over %0d register settings",
             ticks_seen, results_seen, settings_used);
    $display("%0d half-cycle turns, %0d ticks with cycling off, %0d long output hold-offs",
             turns, held_ticks, hold_requests);
    if (mismatches == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/plwg_pkg.sv
rtl/plwg_datapath.sv
rtl/plwg_ctrl.sv
rtl/periodic_level_waveform_generator.sv
tb/lfo_level_checker.sv
tb/periodic_level_waveform_generator_tb.sv
